// ===== src/dna_energy_matrix_site_scanner_unit_macros.svh =====
// Assertion macros shared by the site scanner RTL.
`ifndef DNA_ENERGY_MATRIX_SITE_SCANNER_UNIT_MACROS_SVH
`define DNA_ENERGY_MATRIX_SITE_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while in reset
`define DEMS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dems assertion failed");

// Next-cycle implication, clocked on clk_i, off while in reset
`define DEMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dems assertion failed");

`endif

// ===== src/dems_pkg.sv =====
// Types, codes and helpers of the energy matrix site scanner.
package dems_pkg;

  localparam int WEIGHT_W  = 16;
  localparam int ENERGY_W  = 32;
  localparam int SUM_W     = 40;
  localparam int SYM_W     = 3;
  localparam int POS_W     = 5;
  localparam int REGION_W  = 16;
  localparam int NUM_BASES = 4;
  localparam int NUM_PAIRS = 16;
  localparam int PIDX_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [NUM_BASES-1:0] row_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_BATCH  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RK_SITE   = 2'd0,
    RK_PAIR   = 2'd1,
    RK_REGION = 2'd2
  } rkind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF    = 3'd0,
    CFG_MAX_SITES = 3'd1,
    CFG_POS_A     = 3'd2,
    CFG_POS_B     = 3'd3,
    CFG_SITE_LEN  = 3'd4
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_CALC,
    ST_MUL,
    ST_SUM,
    ST_DECIDE,
    ST_CONS_F,
    ST_CONS_R,
    ST_OUT_F,
    ST_OUT_R,
    ST_OUT_P,
    ST_OUT_G
  } state_e;

  // chain control: parallel load or one-step shift
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-ENERGY_W+1){1'b0}}, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-ENERGY_W+1){1'b1}}, {(ENERGY_W-1){1'b0}}};

  function automatic logic signed [ENERGY_W-1:0] sat_energy(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [ENERGY_W-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(ENERGY_W-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(ENERGY_W-1){1'b0}}};
    end else begin
      r = v[ENERGY_W-1:0];
    end
    return r;
  endfunction

  function automatic weight_t row_max(input row_t r);
    weight_t m;
    m = r[0];
    for (int b = 1; b < NUM_BASES; b++) begin
      if ($signed(r[b]) > $signed(m)) m = r[b];
    end
    return m;
  endfunction

  function automatic weight_t row_min(input row_t r);
    weight_t m;
    m = r[0];
    for (int b = 1; b < NUM_BASES; b++) begin
      if ($signed(r[b]) < $signed(m)) m = r[b];
    end
    return m;
  endfunction

endpackage

// ===== src/dna_energy_matrix_site_scanner_unit.sv =====
// Energy matrix site scanner over both DNA strands. A matrix write, a batch
// start or an ignored item is taken without leaving the idle state. A sequence
// symbol runs the load, scan, calc, mul, sum, decide and two pair-minimum update
// states before its first result beat; its result beats (up to 19) then go out
// as the output takes them. The scan walks the window past one scoring head through
// a chain of MAX_SITE_LENGTH cells, one matrix row per cycle. The output register
// lets the next item be taken while the last result of the previous one still waits.
`include "dna_energy_matrix_site_scanner_unit_macros.svh"
module dna_energy_matrix_site_scanner_unit #(
  parameter int MAX_SITE_LENGTH = 32,
  parameter int REGION_ID_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // weight_position, weight_base, weight_value, symbol, region_id
  input  logic [dems_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // kind
  input  logic [1:0]                          s_axis_tuser_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // strand, region_number, site_position, energy, pair_index, hit
  output logic [dems_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // result_kind
  output logic [1:0]                          m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dems_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dems_pkg::ENERGY_W-1:0]       cfg_data_i
);
  import dems_pkg::*;

  localparam int IdxW = $clog2(MAX_SITE_LENGTH);
  localparam int LenW = $clog2(MAX_SITE_LENGTH + 1);
  localparam int AccW = WEIGHT_W + LenW + 1;
  localparam int CmpW = (LenW > POS_W) ? LenW : POS_W;
  localparam int RegW = (REGION_ID_BITS < REGION_W) ? REGION_ID_BITS : REGION_W;
  localparam int ProdW = ENERGY_W + LenW;

  // input beat fields
  kind_e                 in_kind;
  logic [POS_W-1:0]      in_pos;
  logic [1:0]            in_base;
  weight_t               in_wval;
  logic [SYM_W-1:0]      in_sym_raw;
  logic [SYM_W-1:0]      in_sym;
  logic [REGION_W-1:0]   in_region;
  logic                  in_acc;

  assign in_kind    = kind_e'(s_axis_tuser_i);
  assign in_pos     = s_axis_tdata_i[4:0];
  assign in_base    = s_axis_tdata_i[6:5];
  assign in_wval    = s_axis_tdata_i[22:7];
  assign in_sym_raw = s_axis_tdata_i[25:23];
  assign in_region  = s_axis_tdata_i[41:26];
  assign in_sym     = (in_sym_raw > 3'd4) ? '0 : in_sym_raw;

  state_e state_q, state_d;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  logic signed [ENERGY_W-1:0] cutoff_q;
  logic [15:0]                max_sites_q;
  logic [POS_W-1:0]           pos_a_q;
  logic [POS_W-1:0]           pos_b_q;
  logic [5:0]                 site_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q    <= '0;
      max_sites_q <= '0;
      pos_a_q     <= '0;
      pos_b_q     <= 5'd1;
      site_len_q  <= 6'd32;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CUTOFF:    cutoff_q    <= cfg_data_i;
        CFG_MAX_SITES: max_sites_q <= cfg_data_i[15:0];
        CFG_POS_A:     pos_a_q     <= cfg_data_i[4:0];
        CFG_POS_B:     pos_b_q     <= cfg_data_i[4:0];
        CFG_SITE_LEN:  site_len_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // length in use, clamped to 1..MAX_SITE_LENGTH
  logic [6:0]      sl_ext;
  logic [LenW-1:0] len;
  logic            a_ok, b_ok, pair_ok;

  assign sl_ext = {1'b0, site_len_q};
  always_comb begin
    if (site_len_q == '0) begin
      len = LenW'(1);
    end else if (sl_ext > 7'(MAX_SITE_LENGTH)) begin
      len = LenW'(MAX_SITE_LENGTH);
    end else begin
      len = LenW'(sl_ext);
    end
  end

  assign a_ok    = CmpW'(pos_a_q) < CmpW'(len);
  assign b_ok    = CmpW'(pos_b_q) < CmpW'(len);
  assign pair_ok = a_ok && b_ok;

  // energy matrix rows
  row_t table_q [MAX_SITE_LENGTH];

  always_ff @(posedge clk_i) begin
    if (in_acc && in_kind == KIND_WRITE && 7'(in_pos) < 7'(MAX_SITE_LENGTH)) begin
      table_q[IdxW'(in_pos)][in_base] <= in_wval;
    end
  end

  // window of symbols, newest in slot 0
  logic [SYM_W-1:0] win_q [MAX_SITE_LENGTH];
  logic [15:0]      fill_q;
  logic             end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_SITE_LENGTH; k++) win_q[k] <= '0;
      fill_q <= '0;
    end else if (in_acc && in_kind == KIND_SYMBOL) begin
      win_q[0] <= in_sym;
      for (int k = 1; k < MAX_SITE_LENGTH; k++) win_q[k] <= win_q[k-1];
      if (fill_q != 16'hFFFF) fill_q <= fill_q + 16'd1;
    end else if (state_q == ST_CONS_R && end_q) begin
      for (int k = 0; k < MAX_SITE_LENGTH; k++) win_q[k] <= '0;
      fill_q <= '0;
    end
  end

  // scan chain
  cell_ctrl_t       cell_ctrl;
  row_t             cell_row [MAX_SITE_LENGTH];
  logic [SYM_W-1:0] cell_sa  [MAX_SITE_LENGTH];
  logic [SYM_W-1:0] cell_sb  [MAX_SITE_LENGTH];

  assign cell_ctrl.load  = (state_q == ST_LOAD);
  assign cell_ctrl.shift = (state_q == ST_SCAN);

  for (genvar k = 0; k < MAX_SITE_LENGTH; k++) begin : g_cell
    row_t             nrow;
    logic [SYM_W-1:0] nsa;
    logic [SYM_W-1:0] nsb;
    if (k == MAX_SITE_LENGTH - 1) begin : g_top
      assign nrow = '0;
      assign nsa  = '0;
    end else begin : g_mid
      assign nrow = cell_row[k+1];
      assign nsa  = cell_sa[k+1];
    end
    if (k == 0) begin : g_first
      assign nsb = '0;
    end else begin : g_rest
      assign nsb = cell_sb[k-1];
    end
    dems_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .load_row_i (table_q[k]),
      .load_sym_i (win_q[k]),
      .next_row_i (nrow),
      .next_sa_i  (nsa),
      .next_sb_i  (nsb),
      .row_o      (cell_row[k]),
      .sa_o       (cell_sa[k]),
      .sb_o       (cell_sb[k])
    );
  end

  // scoring head: row i, symbol of slot i (reverse) and of slot L-1-i (forward)
  logic [LenW-1:0]  len_m1;
  row_t             row_h;
  logic [SYM_W-1:0] sa_h, sb_h;
  weight_t          rmax_h, rmin_h;
  assign len_m1 = len - LenW'(1);
  assign row_h  = cell_row[0];
  assign sa_h   = cell_sa[0];
  assign sb_h   = cell_sb[IdxW'(len_m1)];
  assign rmax_h = row_max(row_h);
  assign rmin_h = row_min(row_h);

  logic [IdxW-1:0]             cnt_q;
  logic                        scan_last;
  logic signed [AccW-1:0]      smax_q, smin_q, kf_q, kr_q;
  logic [LenW-1:0]             nu_q;
  row_t                        rowa_q, rowb_q;
  weight_t                     maxa_q, maxb_q;
  logic [SYM_W-1:0]            f1_q, f2_q, r1_q, r2_q;
  logic                        seed_q, win_ok_q;
  logic [REGION_W-1:0]         region_q;
  logic [15:0]                 start_q;
  logic [ENERGY_W-1:0]         pen_q;
  logic signed [SUM_W-1:0]     prod_q;
  logic [ProdW-1:0]            prod_raw;
  logic signed [ENERGY_W-1:0]  fe_q, re_q, rm_q;
  logic signed [ENERGY_W-1:0]  pm_q [NUM_PAIRS];
  logic                        fsite_q, rsite_q;
  logic [15:0]                 sr_q, sr_mid;
  logic                        fsite_d, rsite_d;
  logic [PIDX_W-1:0]           k_q;

  assign scan_last = (LenW'(cnt_q) == len_m1);
  assign prod_raw  = pen_q * nu_q;

  // seeds of the pair minima
  logic signed [ENERGY_W-1:0] seed_val [NUM_PAIRS];
  always_comb begin
    logic signed [SUM_W-1:0] va, vb;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      va = a_ok ? (SUM_W'($signed(rowa_q[k>>2])) - SUM_W'(maxa_q)) : '0;
      vb = b_ok ? (SUM_W'($signed(rowb_q[k&3])) - SUM_W'(maxb_q)) : '0;
      seed_val[k] = sat_energy(SUM_W'(smax_q) + va + vb);
    end
  end

  // site decisions
  always_comb begin
    fsite_d = win_ok_q && (fe_q < cutoff_q) && (sr_q < max_sites_q);
    sr_mid  = sr_q + 16'(fsite_d);
    rsite_d = win_ok_q && (re_q < cutoff_q) && (sr_mid < max_sites_q);
  end

  // pair keys and the single read port of the pair minima
  logic [PIDX_W-1:0]          idx_f, idx_r, pm_idx;
  logic                       val_f, val_r;
  logic signed [ENERGY_W-1:0] pm_rd;
  assign idx_f = {2'(f1_q - 3'd1), 2'(f2_q - 3'd1)};
  assign idx_r = {2'(3'd4 - r1_q), 2'(3'd4 - r2_q)};
  assign val_f = win_ok_q && pair_ok && f1_q != '0 && f2_q != '0;
  assign val_r = win_ok_q && pair_ok && r1_q != '0 && r2_q != '0;
  always_comb begin
    unique case (state_q)
      ST_CONS_F: pm_idx = idx_f;
      ST_CONS_R: pm_idx = idx_r;
      default:   pm_idx = k_q;
    endcase
  end
  assign pm_rd = pm_q[pm_idx];

  // datapath registers of the scoring sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      seed_q   <= 1'b0;
      end_q    <= 1'b0;
      win_ok_q <= 1'b0;
      fsite_q  <= 1'b0;
      rsite_q  <= 1'b0;
      sr_q     <= '0;
      rm_q     <= '0;
      k_q      <= '0;
      for (int k = 0; k < NUM_PAIRS; k++) pm_q[k] <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_kind == KIND_BATCH) sr_q <= '0;
          if (in_acc && in_kind == KIND_SYMBOL) begin
            seed_q   <= (fill_q == '0);
            end_q    <= s_axis_tlast_i;
            region_q <= REGION_W'(in_region[RegW-1:0]);
          end
        end
        ST_LOAD: begin
          cnt_q    <= '0;
          k_q      <= '0;
          smax_q   <= '0;
          smin_q   <= '0;
          kf_q     <= '0;
          kr_q     <= '0;
          nu_q     <= '0;
          win_ok_q <= (fill_q >= 16'(len));
          start_q  <= fill_q - 16'(len) + 16'd1;
        end
        ST_SCAN: begin
          cnt_q  <= cnt_q + IdxW'(1);
          smax_q <= smax_q + AccW'(rmax_h);
          smin_q <= smin_q + AccW'(rmin_h);
          if (sb_h != '0) kf_q <= kf_q + AccW'($signed(row_h[2'(sb_h - 3'd1)]));
          else            nu_q <= nu_q + LenW'(1);
          if (sa_h != '0) kr_q <= kr_q + AccW'($signed(row_h[2'(3'd4 - sa_h)]));
          if (CmpW'(cnt_q) == CmpW'(pos_a_q)) begin
            rowa_q <= row_h;
            maxa_q <= rmax_h;
            f1_q   <= sb_h;
            r1_q   <= sa_h;
          end
          if (CmpW'(cnt_q) == CmpW'(pos_b_q)) begin
            rowb_q <= row_h;
            maxb_q <= rmax_h;
            f2_q   <= sb_h;
            r2_q   <= sa_h;
          end
        end
        ST_CALC: begin
          pen_q <= ENERGY_W'(smax_q - smin_q);
          if (seed_q) begin
            rm_q <= ENERGY_W'(smax_q);
            for (int k = 0; k < NUM_PAIRS; k++) pm_q[k] <= seed_val[k];
          end
        end
        ST_MUL: prod_q <= SUM_W'(prod_raw);
        ST_SUM: begin
          fe_q <= sat_energy(SUM_W'(kf_q) + prod_q);
          re_q <= sat_energy(SUM_W'(kr_q) + prod_q);
        end
        ST_DECIDE: begin
          fsite_q <= fsite_d;
          rsite_q <= rsite_d;
          sr_q    <= sr_mid + 16'(rsite_d);
        end
        ST_CONS_F: begin
          if (val_f && fe_q < pm_rd) begin
            pm_q[idx_f] <= fe_q;
            if (fe_q < rm_q) rm_q <= fe_q;
          end
        end
        ST_CONS_R: begin
          if (val_r && re_q < pm_rd) begin
            pm_q[idx_r] <= re_q;
            if (re_q < rm_q) rm_q <= re_q;
          end
        end
        ST_OUT_P: if (!m_axis_tvalid_o || m_axis_tready_i) k_q <= k_q + PIDX_W'(1);
        default: ;
      endcase
    end
  end

  // output register
  logic                       out_free, out_ld;
  logic                       o_strand, o_hit, o_last;
  rkind_e                     o_kind;
  logic [15:0]                o_pos;
  logic signed [ENERGY_W-1:0] o_energy;
  logic [PIDX_W-1:0]          o_pidx;

  logic                       m_valid_q, m_strand_q, m_hit_q, m_last_q;
  rkind_e                     m_kind_q;
  logic [REGION_W-1:0]        m_region_q;
  logic [15:0]                m_pos_q;
  logic [ENERGY_W-1:0]        m_energy_q;
  logic [PIDX_W-1:0]          m_pidx_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && in_kind == KIND_SYMBOL) state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_CALC;
      ST_CALC:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_CONS_F;
      ST_CONS_F: state_d = ST_CONS_R;
      ST_CONS_R: begin
        priority if (fsite_q) state_d = ST_OUT_F;
        else if (rsite_q)     state_d = ST_OUT_R;
        else if (end_q)       state_d = ST_OUT_P;
        else                  state_d = ST_IDLE;
      end
      ST_OUT_F: begin
        if (out_free) begin
          priority if (rsite_q) state_d = ST_OUT_R;
          else if (end_q)       state_d = ST_OUT_P;
          else                  state_d = ST_IDLE;
        end
      end
      ST_OUT_R: if (out_free) state_d = end_q ? ST_OUT_P : ST_IDLE;
      ST_OUT_P: if (out_free && k_q == '1) state_d = ST_OUT_G;
      ST_OUT_G: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // result beat contents
  always_comb begin
    out_ld   = 1'b0;
    o_kind   = RK_SITE;
    o_strand = 1'b0;
    o_pos    = '0;
    o_energy = fe_q;
    o_pidx   = '0;
    o_hit    = 1'b0;
    o_last   = 1'b0;
    unique case (state_q)
      ST_OUT_F: begin
        out_ld = out_free;
        o_pos  = start_q;
        o_last = !rsite_q && !end_q;
      end
      ST_OUT_R: begin
        out_ld   = out_free;
        o_strand = 1'b1;
        o_pos    = start_q;
        o_energy = re_q;
        o_last   = !end_q;
      end
      ST_OUT_P: begin
        out_ld   = out_free;
        o_kind   = RK_PAIR;
        o_energy = pm_rd;
        o_pidx   = k_q;
      end
      ST_OUT_G: begin
        out_ld   = out_free;
        o_kind   = RK_REGION;
        o_energy = rm_q;
        o_hit    = (rm_q < cutoff_q);
        o_last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_ld)               m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      m_kind_q   <= o_kind;
      m_strand_q <= o_strand;
      m_region_q <= region_q;
      m_pos_q    <= o_pos;
      m_energy_q <= o_energy;
      m_pidx_q   <= o_pidx;
      m_hit_q    <= o_hit;
      m_last_q   <= o_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {2'b00, m_hit_q, m_pidx_q, m_energy_q, m_pos_q, m_region_q,
                            m_strand_q};

  `DEMS_ASSERT_NEXT(a_scan_done, state_q == ST_SCAN && scan_last, state_q == ST_CALC)
  `DEMS_ASSERT_NEXT(a_sym_start, in_acc && in_kind == KIND_SYMBOL, state_q == ST_LOAD)
  `DEMS_ASSERT_NEXT(a_region_last, state_q == ST_OUT_G && out_free, m_axis_tvalid_o && m_axis_tlast_o)

endmodule

// ===== src/dems_cell.sv =====
// One cell of the scan chain: a matrix row and two copies of a window symbol.
module dems_cell (
  input  logic                         clk_i,
  input  dems_pkg::cell_ctrl_t         ctrl_i,
  input  dems_pkg::row_t               load_row_i,
  input  logic [dems_pkg::SYM_W-1:0]   load_sym_i,
  input  dems_pkg::row_t               next_row_i,  // from the cell above
  input  logic [dems_pkg::SYM_W-1:0]   next_sa_i,   // from the cell above
  input  logic [dems_pkg::SYM_W-1:0]   next_sb_i,   // from the cell below
  output dems_pkg::row_t               row_o,
  output logic [dems_pkg::SYM_W-1:0]   sa_o,
  output logic [dems_pkg::SYM_W-1:0]   sb_o
);
  import dems_pkg::*;

  row_t             row_q;
  logic [SYM_W-1:0] sa_q;
  logic [SYM_W-1:0] sb_q;

  // rows and the a-copy move towards the head, the b-copy moves away from it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      row_q <= load_row_i;
      sa_q  <= load_sym_i;
      sb_q  <= load_sym_i;
    end else if (ctrl_i.shift) begin
      row_q <= next_row_i;
      sa_q  <= next_sa_i;
      sb_q  <= next_sb_i;
    end
  end

  assign row_o = row_q;
  assign sa_o  = sa_q;
  assign sb_o  = sb_q;

endmodule

// ===== tb/sv/dna_energy_matrix_site_scanner_unit_tb.sv =====
// Testbench for the energy matrix site scanner: random stream with a scoreboard.
module dna_energy_matrix_site_scanner_unit_tb;
  import dems_pkg::*;

  typedef struct packed {
    rkind_e      rk;
    bit          strand;
    bit [15:0]   region;
    bit [15:0]   spos;
    bit [31:0]   energy;
    bit [3:0]    pidx;
    bit          hit;
    bit          last;
  } scan_beat_t;

  // Scoreboard: predicts the result beats of each accepted item and checks them
  class site_scan_ledger;
    int          wtab[32][4];
    int          pos_max[32];
    byte         win[32];
    int unsigned fill;
    int unsigned sites_done;
    int          reg_min;
    int          pair_min[16];
    int          penalty;
    int          top_energy;
    longint      cutoff;
    int unsigned max_sites;
    int unsigned pos_a;
    int unsigned pos_b;
    int unsigned site_len;
    scan_beat_t  expected_beats[$];
    int          mismatches;
    int          beats_seen;

    function new();
      foreach (win[i]) win[i] = 0;
      foreach (wtab[i, b]) wtab[i][b] = 0;
      fill = 0; sites_done = 0;
      cutoff = 0; max_sites = 0; pos_a = 0; pos_b = 1; site_len = 32;
      mismatches = 0; beats_seen = 0;
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function int unsigned eff_len();
      if (site_len == 0) return 1;
      if (site_len > 32) return 32;
      return site_len;
    endfunction

    function void set_reg(cfg_e idx, bit [31:0] val);
      case (idx)
        CFG_CUTOFF:    cutoff = longint'($signed(val));
        CFG_MAX_SITES: max_sites = val[15:0];
        CFG_POS_A:     pos_a = val[4:0];
        CFG_POS_B:     pos_b = val[4:0];
        CFG_SITE_LEN:  site_len = val[5:0];
        default: ;
      endcase
    endfunction

    // Row maxima, unknown penalty and highest possible site energy
    function void refresh_bounds(int unsigned len);
      longint smax, smin;
      int mx, mn;
      smax = 0; smin = 0;
      for (int i = 0; i < 32; i++) begin
        mx = wtab[i][0]; mn = mx;
        for (int b = 1; b < 4; b++) begin
          if (wtab[i][b] > mx) mx = wtab[i][b];
          if (wtab[i][b] < mn) mn = wtab[i][b];
        end
        pos_max[i] = mx;
        if (i < len) begin
          smax += mx; smin += mn;
        end
      end
      top_energy = sat32(smax);
      penalty = sat32(smax - smin);
    endfunction

    function void seed_minima(int unsigned len);
      longint v;
      refresh_bounds(len);
      reg_min = top_energy;
      for (int k = 0; k < 16; k++) begin
        v = top_energy;
        if (pos_a < len) v += longint'(wtab[pos_a][k >> 2]) - pos_max[pos_a];
        if (pos_b < len) v += longint'(wtab[pos_b][k & 3]) - pos_max[pos_b];
        pair_min[k] = sat32(v);
      end
    endfunction

    function void lower_minima(int e, bit ok, int idx);
      if (ok && e < pair_min[idx & 15]) begin
        pair_min[idx & 15] = e;
        if (e < reg_min) reg_min = e;
      end
    endfunction

    // Work out the result beats of one accepted item
    function void note_item(kind_e kind, bit [4:0] wpos, bit [1:0] wbase, bit [15:0] wval,
                            bit [2:0] sym_in, bit [15:0] rid, bit rend);
      scan_beat_t  outs[$];
      scan_beat_t  bt;
      int unsigned len, start;
      int          sym, s, fe, re, f1, f2, r1, r2;
      longint      fw, rc;
      bit          ok;
      len = eff_len();
      case (kind)
        KIND_WRITE: begin
          wtab[wpos][wbase] = int'($signed(wval));
          return;
        end
        KIND_BATCH: begin
          sites_done = 0;
          return;
        end
        KIND_SYMBOL: ;
        default: return;
      endcase
      if (fill == 0) seed_minima(len);
      refresh_bounds(len);
      sym = (sym_in > 4) ? 0 : sym_in;
      for (int j = 31; j > 0; j--) win[j] = win[j-1];
      win[0] = byte'(sym);
      if (fill < 65535) fill++;
      bt = '{RK_SITE, 0, rid, 0, 0, 0, 0, 0};
      if (fill >= len) begin
        fw = 0; rc = 0;
        start = fill - len + 1;
        for (int i = 0; i < len; i++) begin
          s = win[len-1-i];
          if (s == 0) begin
            fw += penalty; rc += penalty;
          end else begin
            fw += wtab[i][s-1];
            rc += wtab[len-1-i][4-s];
          end
        end
        fe = sat32(fw); re = sat32(rc);
        bt.spos = 16'(start);
        if (longint'(fe) < cutoff && sites_done < max_sites) begin
          bt.strand = 0; bt.energy = fe; outs.push_back(bt);
          sites_done++;
        end
        if (longint'(re) < cutoff && sites_done < max_sites) begin
          bt.strand = 1; bt.energy = re; outs.push_back(bt);
          sites_done++;
        end
        ok = (pos_a < len) && (pos_b < len);
        f1 = 0; f2 = 0; r1 = 0; r2 = 0;
        if (ok) begin
          f1 = win[len-1-pos_a]; f2 = win[len-1-pos_b];
          r1 = win[pos_a];       r2 = win[pos_b];
        end
        lower_minima(fe, ok && f1 != 0 && f2 != 0, 4*(f1-1) + (f2-1));
        lower_minima(re, ok && r1 != 0 && r2 != 0, 4*(4-r1) + (4-r2));
      end
      // Region close: pair minima in index order, then the region minimum
      if (rend) begin
        bt.strand = 0; bt.spos = 0;
        for (int k = 0; k < 16; k++) begin
          bt.rk = RK_PAIR; bt.energy = pair_min[k]; bt.pidx = 4'(k);
          outs.push_back(bt);
        end
        bt.rk = RK_REGION; bt.energy = reg_min; bt.pidx = 0;
        bt.hit = (longint'(reg_min) < cutoff);
        outs.push_back(bt);
        foreach (win[i]) win[i] = 0;
        fill = 0;
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1;
      foreach (outs[i]) expected_beats.push_back(outs[i]);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_beat(scan_beat_t got);
      scan_beat_t exp_b;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d energy %0d", got.rk, $signed(got.energy));
        return;
      end
      exp_b = expected_beats.pop_front();
      if (got != exp_b) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: kind %0d str %0d reg %0d pos %0d en %0d pidx %0d hit %0d last %0d",
                   exp_b.rk, exp_b.strand, exp_b.region, exp_b.spos, $signed(exp_b.energy),
                   exp_b.pidx, exp_b.hit, exp_b.last);
          $display("         got: kind %0d str %0d reg %0d pos %0d en %0d pidx %0d hit %0d last %0d",
                   got.rk, got.strand, got.region, got.spos, $signed(got.energy),
                   got.pidx, got.hit, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [1:0]            s_axis_tuser_i = '0;
  logic                  s_axis_tlast_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [ENERGY_W-1:0]   cfg_data_i = '0;

  site_scan_ledger ledger = new();
  int  items_sent = 0;

  dna_energy_matrix_site_scanner_unit uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(12 * 5000000);
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  // Random gap: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: sample beats and drive tready with stalls
  initial begin
    scan_beat_t got;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.rk     = rkind_e'(m_axis_tuser_o);
        got.strand = m_axis_tdata_o[0];
        got.region = m_axis_tdata_o[16:1];
        got.spos   = m_axis_tdata_o[32:17];
        got.energy = m_axis_tdata_o[64:33];
        got.pidx   = m_axis_tdata_o[68:65];
        got.hit    = m_axis_tdata_o[69];
        got.last   = m_axis_tlast_o;
        ledger.check_beat(got);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Drive one input beat and wait for its handshake
  task automatic send_item(kind_e kind, bit [4:0] wpos, bit [1:0] wbase, bit [15:0] wval,
                           bit [2:0] sym, bit [15:0] rid, bit rend);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tlast_i  <= rend;
    s_axis_tdata_i  <= {6'd0, rid, sym, wval, wbase, wpos};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    ledger.note_item(kind, wpos, wbase, wval, sym, rid, rend);
    items_sent++;
  endtask

  task automatic send_symbol(bit [2:0] sym, bit [15:0] rid, bit rend);
    send_item(KIND_SYMBOL, 5'($urandom), 2'($urandom), 16'($urandom), sym, rid, rend);
  endtask

  task automatic send_weight(bit [4:0] p, bit [1:0] b, bit [15:0] v);
    send_item(KIND_WRITE, p, b, v, 3'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // Hold the sender until every expected beat is back, then let the block settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.expected_beats.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Write all five registers back to back, block idle
  task automatic write_regs(bit [31:0] cut, bit [15:0] ms, bit [4:0] pa, bit [4:0] pb,
                            bit [5:0] len);
    bit [31:0] vals[5];
    vals = '{cut, {16'd0, ms}, {27'd0, pa}, {27'd0, pb}, {26'd0, len}};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_e'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      ledger.set_reg(cfg_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic bit [2:0] pick_symbol();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return 3'($urandom_range(1, 4));
    if (r < 18) return 3'd0;
    return 3'($urandom_range(5, 7));
  endfunction

  function automatic bit [15:0] pick_weight();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    if (r < 4) return 16'($urandom);
    return 16'($signed($urandom_range(0, 1600)) - 800);
  endfunction

  // Stimulus
  initial begin
    bit [15:0] rid;
    int        rlen, n_random, r, len, lens[8], cut_pick;
    bit [31:0] cut;
    bit [15:0] ms;
    lens = '{0, 1, 2, 5, 12, 32, 40, 63};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full matrix load so no entry is read before it is written
    for (int p = 0; p < 32; p++)
      for (int b = 0; b < 4; b++)
        send_weight(5'(p), 2'(b), pick_weight());

    // Directed: ignored kind, batch start, unknowns and out-of-range symbols,
    // short regions
    send_item(KIND_NONE, '1, '1, '1, '1, '1, 1'b1);
    send_item(KIND_BATCH, '0, '0, '0, '0, '0, 1'b0);
    for (int i = 0; i < 3; i++) send_symbol(3'(i + 1), 16'hffff, i == 2);
    send_symbol(3'd4, 16'h0000, 1'b1);
    drain();
    write_regs(32'h7fffffff, 16'hffff, 5'd0, 5'd31, 6'd32);
    for (int i = 0; i < 34; i++)
      send_symbol((i == 3) ? 3'd0 : (i == 5) ? 3'd7 : (i == 9) ? 3'd5 : 3'(1 + i % 4),
                  16'h5a5a, i == 33);
    drain();

    // Random phases over many register settings
    n_random = 0;
    while (n_random < 250) begin
      len = lens[$urandom_range(0, 7)];
      cut_pick = $urandom_range(0, 5);
      cut = (cut_pick == 0) ? 32'h80000000 : (cut_pick == 1) ? 32'h7fffffff :
            (cut_pick == 2) ? 32'd0 : 32'($signed($urandom_range(0, 12000)) - 6000);
      r = $urandom_range(0, 3);
      ms = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : 16'($urandom_range(1, 20));
      write_regs(cut, ms, 5'($urandom), ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd1,
                 6'(len));
      if (len == 0) len = 1;
      if (len > 32) len = 32;
      send_item(KIND_BATCH, '0, '0, '0, '0, '0, 1'($urandom));
      for (int reg_n = 0; reg_n < 3; reg_n++) begin
        rid = 16'($urandom);
        rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len) :
               $urandom_range(len, len + 12);
        for (int i = 0; i < rlen; i++) begin
          r = $urandom_range(0, 29);
          if (r == 0) send_weight(5'($urandom), 2'($urandom), pick_weight());
          else if (r == 1) send_item(KIND_BATCH, 5'($urandom), 2'($urandom), 16'($urandom),
                                     3'($urandom), rid, 1'($urandom));
          else if (r == 2) send_item(KIND_NONE, 5'($urandom), 2'($urandom), 16'($urandom),
                                     3'($urandom), rid, 1'($urandom));
          send_symbol(pick_symbol(), rid, i == rlen - 1);
          n_random++;
        end
      end
      drain();
    end

    if (ledger.expected_beats.size() != 0) ledger.mismatches++;
    $display("Run covered %0d input beats and %0d result beats over several register settings,",
             items_sent, ledger.beats_seen);
    $display("with short regions, unknown symbols and site budgets; %0d mismatches.",
             ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
